// ===== hdl/bsm_pkg.sv =====
// Shared types and constants for the bank switch mapper.
`timescale 1ns / 1ps
`default_nettype none
package bsm_pkg;

    localparam int CMD_W      = 2;
    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 8;
    localparam int MAP_W      = 19;
    localparam int COUNT_W    = 7;
    localparam int PRG_BANK_W = 6;
    localparam int CHR_BANK_W = 8;
    localparam int TARGET_W   = 3;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PRG_READ  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PRG_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CHR       = 2'd2;
    localparam logic [CMD_W-1:0] CMD_TICK      = 2'd3;

    // Register regions within 0x8000-0xFFFF
    localparam logic [1:0] REG_BANK   = 2'd0;
    localparam logic [1:0] REG_MIRROR = 2'd1;
    localparam logic [1:0] REG_IRQ    = 2'd2;
    localparam logic [1:0] REG_IRQ_EN = 2'd3;

    // Bank select targets
    localparam logic [TARGET_W-1:0] TGT_CHR_2K_0 = 3'd0;
    localparam logic [TARGET_W-1:0] TGT_CHR_2K_1 = 3'd1;
    localparam logic [TARGET_W-1:0] TGT_CHR_1K_0 = 3'd2;
    localparam logic [TARGET_W-1:0] TGT_CHR_1K_1 = 3'd3;
    localparam logic [TARGET_W-1:0] TGT_CHR_1K_2 = 3'd4;
    localparam logic [TARGET_W-1:0] TGT_CHR_1K_3 = 3'd5;
    localparam logic [TARGET_W-1:0] TGT_PRG_SWAP = 3'd6;
    localparam logic [TARGET_W-1:0] TGT_PRG_MID  = 3'd7;

    // Reset values
    localparam logic [COUNT_W-1:0]    PRG_COUNT_RST = 7'd64;
    localparam logic [PRG_BANK_W-1:0] PRG_BANK0_RST = 6'd0;
    localparam logic [PRG_BANK_W-1:0] PRG_BANK1_RST = 6'd1;
    localparam logic [PRG_BANK_W-1:0] PRG_BANK2_RST = 6'(PRG_COUNT_RST - 7'd2);
    localparam logic [PRG_BANK_W-1:0] PRG_BANK3_RST = 6'(PRG_COUNT_RST - 7'd1);

    typedef struct packed {
        logic [MAP_W-1:0] mapped_address;
        logic             ram_select;
        logic             irq;
        logic             mirror_horizontal;
        logic             ram_enabled;
        logic             ram_write_protect;
    } t_result;

endpackage
`default_nettype wire

// ===== hdl/bsm_core.sv =====
// Mapper state, register writes, scanline counter and address mapping.
`timescale 1ns / 1ps
`default_nettype none
module bsm_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [bsm_pkg::COUNT_W-1:0]   i_cfg_wdata,
    input  wire logic                          i_accept,
    input  wire logic [bsm_pkg::CMD_W-1:0]     i_cmd,
    input  wire logic [bsm_pkg::ADDR_W-1:0]    i_address,
    input  wire logic [bsm_pkg::DATA_W-1:0]    i_data,
    output bsm_pkg::t_result                   o_result
);
    import bsm_pkg::*;

    logic [COUNT_W-1:0]    r_count,      n_count;
    logic [TARGET_W-1:0]   r_target,     n_target;
    logic                  r_prg_mode,   n_prg_mode;
    logic                  r_chr_mode,   n_chr_mode;
    logic [PRG_BANK_W-1:0] r_prg [4];
    logic [PRG_BANK_W-1:0] n_prg [4];
    logic [CHR_BANK_W-1:0] r_chr [6];
    logic [CHR_BANK_W-1:0] n_chr [6];
    logic                  r_mirror,     n_mirror;
    logic                  r_ram_en,     n_ram_en;
    logic                  r_protect,    n_protect;
    logic                  r_irq_en,     n_irq_en;
    logic [DATA_W-1:0]     r_reload,     n_reload;
    logic [DATA_W-1:0]     r_irq_cnt,    n_irq_cnt;
    logic                  r_pending,    n_pending;

    logic                  ram_win;
    logic                  reg_win;
    logic [1:0]            region;
    logic                  odd;
    logic                  new_mode;
    logic [PRG_BANK_W-1:0] cnt_m2;
    logic                  chr_hi;
    logic [2:0]            chr_idx;
    logic [CHR_BANK_W-1:0] chr_sel;
    logic [MAP_W-1:0]      mapped;

    assign ram_win  = (i_address[15:13] == 3'b011);
    assign reg_win  = i_address[15];
    assign region   = i_address[14:13];
    assign odd      = i_address[0];
    assign new_mode = i_data[6];
    assign cnt_m2   = PRG_BANK_W'(r_count - COUNT_W'(2));

    // State update
    always_comb begin
        n_count    = r_count;
        n_target   = r_target;
        n_prg_mode = r_prg_mode;
        n_chr_mode = r_chr_mode;
        n_prg      = r_prg;
        n_chr      = r_chr;
        n_mirror   = r_mirror;
        n_ram_en   = r_ram_en;
        n_protect  = r_protect;
        n_irq_en   = r_irq_en;
        n_reload   = r_reload;
        n_irq_cnt  = r_irq_cnt;
        n_pending  = r_pending;
        if (i_cfg_we) begin
            n_count = i_cfg_wdata;
        end
        if (i_accept) begin
            if (i_cmd == CMD_PRG_WRITE && reg_win) begin
                unique case (region)
                    REG_BANK: begin
                        if (!odd) begin
                            n_target   = i_data[TARGET_W-1:0];
                            n_prg_mode = new_mode;
                            n_chr_mode = i_data[7];
                            // switchable bank follows the mode into the other slot
                            if (new_mode) begin
                                n_prg[2] = (new_mode != r_prg_mode) ? r_prg[0] : r_prg[2];
                                n_prg[0] = cnt_m2;
                            end else begin
                                n_prg[0] = (new_mode != r_prg_mode) ? r_prg[2] : r_prg[0];
                                n_prg[2] = cnt_m2;
                            end
                        end else begin
                            unique case (r_target)
                                TGT_CHR_2K_0: n_chr[0] = {i_data[7:1], 1'b0};
                                TGT_CHR_2K_1: n_chr[1] = {i_data[7:1], 1'b0};
                                TGT_CHR_1K_0: n_chr[2] = i_data;
                                TGT_CHR_1K_1: n_chr[3] = i_data;
                                TGT_CHR_1K_2: n_chr[4] = i_data;
                                TGT_CHR_1K_3: n_chr[5] = i_data;
                                TGT_PRG_SWAP: begin
                                    if (r_prg_mode) begin
                                        n_prg[2] = i_data[PRG_BANK_W-1:0];
                                    end else begin
                                        n_prg[0] = i_data[PRG_BANK_W-1:0];
                                    end
                                end
                                TGT_PRG_MID:  n_prg[1] = i_data[PRG_BANK_W-1:0];
                                default:      n_prg[1] = r_prg[1];
                            endcase
                        end
                    end
                    REG_MIRROR: begin
                        if (!odd) begin
                            n_mirror = i_data[0];
                        end else begin
                            n_protect = i_data[6];
                            n_ram_en  = i_data[7];
                        end
                    end
                    REG_IRQ: begin
                        if (!odd) begin
                            n_reload = i_data;
                        end else begin
                            n_irq_cnt = '0;
                        end
                    end
                    REG_IRQ_EN: begin
                        if (!odd) begin
                            n_irq_en  = 1'b0;
                            n_pending = 1'b0;
                        end else begin
                            n_irq_en = 1'b1;
                        end
                    end
                    default: n_irq_en = r_irq_en;
                endcase
            end else if (i_cmd == CMD_TICK) begin
                if (r_irq_cnt == '0) begin
                    n_irq_cnt = r_reload;
                    if (r_irq_en) begin
                        n_pending = 1'b1;
                    end
                end else begin
                    n_irq_cnt = r_irq_cnt - DATA_W'(1);
                end
            end
        end
    end

    // Address mapping from the state before this transaction
    assign chr_hi  = i_address[12] ^ r_chr_mode;
    assign chr_idx = chr_hi ? (3'd2 + {1'b0, i_address[11:10]}) : {2'b00, i_address[11]};
    assign chr_sel = r_chr[chr_idx];

    always_comb begin
        mapped = '0;
        unique case (i_cmd)
            CMD_PRG_READ: begin
                if (ram_win) begin
                    mapped = MAP_W'(i_address[12:0]);
                end else if (reg_win) begin
                    mapped = {r_prg[i_address[14:13]], i_address[12:0]};
                end
            end
            CMD_PRG_WRITE: begin
                if (ram_win) begin
                    mapped = MAP_W'(i_address[12:0]);
                end
            end
            CMD_CHR: begin
                if (i_address[15:13] == 3'b000) begin
                    if (chr_hi) begin
                        mapped = {1'b0, chr_sel, 10'b0} + MAP_W'(i_address[9:0]);
                    end else begin
                        mapped = {1'b0, chr_sel, 10'b0} + MAP_W'(i_address[10:0]);
                    end
                end
            end
            CMD_TICK: mapped = '0;
            default:  mapped = '0;
        endcase
    end

    always_comb begin
        o_result.mapped_address    = mapped;
        o_result.ram_select        = ram_win && (i_cmd == CMD_PRG_READ || i_cmd == CMD_PRG_WRITE);
        o_result.irq               = n_pending;
        o_result.mirror_horizontal = n_mirror;
        o_result.ram_enabled       = n_ram_en;
        o_result.ram_write_protect = n_protect;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= PRG_COUNT_RST;
            r_target   <= '0;
            r_prg_mode <= 1'b0;
            r_chr_mode <= 1'b0;
            r_prg[0]   <= PRG_BANK0_RST;
            r_prg[1]   <= PRG_BANK1_RST;
            r_prg[2]   <= PRG_BANK2_RST;
            r_prg[3]   <= PRG_BANK3_RST;
            for (int i = 0; i < 6; i++) begin
                r_chr[i] <= '0;
            end
            r_mirror   <= 1'b1;
            r_ram_en   <= 1'b0;
            r_protect  <= 1'b0;
            r_irq_en   <= 1'b0;
            r_reload   <= '0;
            r_irq_cnt  <= '0;
            r_pending  <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_target   <= n_target;
            r_prg_mode <= n_prg_mode;
            r_chr_mode <= n_chr_mode;
            r_prg      <= n_prg;
            r_chr      <= n_chr;
            r_mirror   <= n_mirror;
            r_ram_en   <= n_ram_en;
            r_protect  <= n_protect;
            r_irq_en   <= n_irq_en;
            r_reload   <= n_reload;
            r_irq_cnt  <= n_irq_cnt;
            r_pending  <= n_pending;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/bsm_outbuf.sv =====
// Result register with a skid stage on the output channel.
`timescale 1ns / 1ps
`default_nettype none
module bsm_outbuf (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  wire bsm_pkg::t_result i_result,
    output logic            o_full,
    output logic            o_valid,
    input  wire logic       i_stall,
    output bsm_pkg::t_result o_result
);
    import bsm_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    drain;

    assign drain    = r_out_valid && !i_stall;
    assign o_full   = r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (drain) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || drain) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (drain) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload: skid holds a transaction only while the output slot is stalled
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (drain) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (!r_out_valid || drain) begin
                r_out <= i_result;
            end else begin
                r_skid <= i_result;
            end
        end
    end

endmodule
`default_nettype wire

// ===== hdl/bank_switch_mapper_with_scanline_irq.sv =====
// Top level of the bank switch mapper with scanline interrupt counter.
// Input channel: i_in_valid / o_in_stall carrying i_cmd, i_address, i_data.
// Each transaction is a program read, program write, pattern access or
// scanline tick, and yields exactly one result on the output channel
// (o_out_valid / i_out_stall): mapped address, work RAM select, IRQ level,
// mirroring and the work RAM enable and protect bits after the transaction.
// Results are registered on acceptance; one transaction is taken per
// cycle while o_in_stall is low, the mapping and register update being
// one short combinational pass into the result register.
// The bank count register is written through i_cfg_we / i_cfg_wdata; the
// next bank select write loads the count minus two into the fixed slot.
// A two-entry output buffer (result register plus skid) lets a new
// transaction be taken while a result waits; the input stalls only when
// both entries are full. Results are never dropped or reordered.
// Reset (synchronous, i_rst_n low) restores the bank count to 64, the
// default bank layout, horizontal mirroring and a cleared IRQ counter,
// and empties the output buffer.
`timescale 1ns / 1ps
`default_nettype none
module bank_switch_mapper_with_scanline_irq (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [bsm_pkg::COUNT_W-1:0]  i_cfg_wdata,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [bsm_pkg::CMD_W-1:0]    i_cmd,
    input  wire logic [bsm_pkg::ADDR_W-1:0]   i_address,
    input  wire logic [bsm_pkg::DATA_W-1:0]   i_data,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic [bsm_pkg::MAP_W-1:0]         o_mapped_address,
    output logic                              o_ram_select,
    output logic                              o_irq,
    output logic                              o_mirror_horizontal,
    output logic                              o_ram_enabled,
    output logic                              o_ram_write_protect
);
    import bsm_pkg::*;

    logic    accept;
    logic    buf_full;
    t_result core_result;
    t_result out_result;

    assign o_in_stall = buf_full;
    assign accept     = i_in_valid && !buf_full;

    bsm_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_cmd       (i_cmd),
        .i_address   (i_address),
        .i_data      (i_data),
        .o_result    (core_result)
    );

    bsm_outbuf u_outbuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (accept),
        .i_result (core_result),
        .o_full   (buf_full),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_result (out_result)
    );

    assign o_mapped_address    = out_result.mapped_address;
    assign o_ram_select        = out_result.ram_select;
    assign o_irq               = out_result.irq;
    assign o_mirror_horizontal = out_result.mirror_horizontal;
    assign o_ram_enabled       = out_result.ram_enabled;
    assign o_ram_write_protect = out_result.ram_write_protect;

endmodule
`default_nettype wire
